### rtl/core/vector_slew_limiter_defines.svh
// Assertion macros shared by the vector slew limiter RTL.
`ifndef VECTOR_SLEW_LIMITER_DEFINES_SVH
`define VECTOR_SLEW_LIMITER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define VSL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector_slew_limiter: assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define VSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector_slew_limiter: assertion failed");

`endif

### rtl/core/vsl_pkg.sv
// Shared widths, constants and control types of the vector slew limiter.
package vsl_pkg;

    localparam int DataW     = 32;
    localparam int DiffW     = DataW + 1;
    localparam int MagW      = DataW;
    localparam int CapW      = 31;
    localparam int AccW      = 2 * MagW + 2;
    localparam int AluW      = AccW + 1;
    localparam int RootW     = AccW / 2;
    localparam int RemW      = RootW + 2;
    localparam int ProdW     = MagW + CapW;
    localparam int SqrtSteps = AccW / 2;
    localparam int NumComp   = 3;
    localparam int CompW     = 2;
    localparam int CntW      = $clog2(SqrtSteps);

    localparam logic [CapW-1:0]  MaxStepReset = CapW'(6554);
    localparam logic [DataW-1:0] SatMax       = {1'b0, {(DataW-1){1'b1}}};
    localparam logic [DataW-1:0] SatMin       = {1'b1, {(DataW-1){1'b0}}};
    localparam logic [CompW-1:0] LastComp     = CompW'(NumComp - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_DIFF,
        ST_SQ_LOAD,
        ST_SQ_STEP,
        ST_SQRT_LOAD,
        ST_SQRT_STEP,
        ST_CHECK,
        ST_MUL_LOAD,
        ST_MUL_STEP,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_APPLY,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DIFF,
        OP_SQ_LOAD,
        OP_SQ_STEP,
        OP_SQRT_LOAD,
        OP_SQRT_STEP,
        OP_CHECK,
        OP_MUL_LOAD,
        OP_MUL_STEP,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_APPLY
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CompW-1:0] comp;
    } ctrl_t;

endpackage

### rtl/core/vsl_seq.sv
// Sequencer that steps the shared arithmetic unit through one transaction.
module vsl_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic           out_free,
    input  logic           restart,
    input  logic           has_last,
    input  logic           check_limited,
    output vsl_pkg::ctrl_t ctrl,
    output logic           in_ready,
    output logic           done
);

    vsl_pkg::state_t                 state_reg, state_next;
    logic [vsl_pkg::CntW-1:0]        cnt_reg, cnt_next;
    logic [vsl_pkg::CompW-1:0]       comp_reg, comp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vsl_pkg::ST_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        case (state_reg)
            vsl_pkg::ST_IDLE:
            begin
                if (in_fire)
                    state_next = vsl_pkg::ST_START;
            end
            vsl_pkg::ST_START:
            begin
                if (restart || !has_last)
                    state_next = vsl_pkg::ST_DONE;
                else
                begin
                    state_next = vsl_pkg::ST_DIFF;
                    comp_next  = '0;
                end
            end
            vsl_pkg::ST_DIFF:
            begin
                if (comp_reg == vsl_pkg::LastComp)
                begin
                    state_next = vsl_pkg::ST_SQ_LOAD;
                    comp_next  = '0;
                end
                else
                    comp_next = comp_reg + 1'b1;
            end
            vsl_pkg::ST_SQ_LOAD:
            begin
                state_next = vsl_pkg::ST_SQ_STEP;
                cnt_next   = '0;
            end
            vsl_pkg::ST_SQ_STEP:
            begin
                if (cnt_reg == vsl_pkg::CntW'(vsl_pkg::MagW - 1))
                begin
                    if (comp_reg == vsl_pkg::LastComp)
                        state_next = vsl_pkg::ST_SQRT_LOAD;
                    else
                    begin
                        state_next = vsl_pkg::ST_SQ_LOAD;
                        comp_next  = comp_reg + 1'b1;
                    end
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            vsl_pkg::ST_SQRT_LOAD:
            begin
                state_next = vsl_pkg::ST_SQRT_STEP;
                cnt_next   = '0;
            end
            vsl_pkg::ST_SQRT_STEP:
            begin
                if (cnt_reg == vsl_pkg::CntW'(vsl_pkg::SqrtSteps - 1))
                    state_next = vsl_pkg::ST_CHECK;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            vsl_pkg::ST_CHECK:
            begin
                if (check_limited)
                begin
                    state_next = vsl_pkg::ST_MUL_LOAD;
                    comp_next  = '0;
                end
                else
                    state_next = vsl_pkg::ST_DONE;
            end
            vsl_pkg::ST_MUL_LOAD:
            begin
                state_next = vsl_pkg::ST_MUL_STEP;
                cnt_next   = '0;
            end
            vsl_pkg::ST_MUL_STEP:
            begin
                if (cnt_reg == vsl_pkg::CntW'(vsl_pkg::CapW - 1))
                    state_next = vsl_pkg::ST_DIV_LOAD;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            vsl_pkg::ST_DIV_LOAD:
            begin
                state_next = vsl_pkg::ST_DIV_STEP;
                cnt_next   = '0;
            end
            vsl_pkg::ST_DIV_STEP:
            begin
                if (cnt_reg == vsl_pkg::CntW'(vsl_pkg::CapW - 1))
                    state_next = vsl_pkg::ST_APPLY;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            vsl_pkg::ST_APPLY:
            begin
                if (comp_reg == vsl_pkg::LastComp)
                    state_next = vsl_pkg::ST_DONE;
                else
                begin
                    state_next = vsl_pkg::ST_MUL_LOAD;
                    comp_next  = comp_reg + 1'b1;
                end
            end
            vsl_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = vsl_pkg::ST_IDLE;
            end
            default:
                state_next = vsl_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.comp = comp_reg;
        in_ready  = (state_reg == vsl_pkg::ST_IDLE);
        done      = (state_reg == vsl_pkg::ST_DONE);
        case (state_reg)
            vsl_pkg::ST_DIFF:      ctrl.op = vsl_pkg::OP_DIFF;
            vsl_pkg::ST_SQ_LOAD:   ctrl.op = vsl_pkg::OP_SQ_LOAD;
            vsl_pkg::ST_SQ_STEP:   ctrl.op = vsl_pkg::OP_SQ_STEP;
            vsl_pkg::ST_SQRT_LOAD: ctrl.op = vsl_pkg::OP_SQRT_LOAD;
            vsl_pkg::ST_SQRT_STEP: ctrl.op = vsl_pkg::OP_SQRT_STEP;
            vsl_pkg::ST_CHECK:     ctrl.op = vsl_pkg::OP_CHECK;
            vsl_pkg::ST_MUL_LOAD:  ctrl.op = vsl_pkg::OP_MUL_LOAD;
            vsl_pkg::ST_MUL_STEP:  ctrl.op = vsl_pkg::OP_MUL_STEP;
            vsl_pkg::ST_DIV_LOAD:  ctrl.op = vsl_pkg::OP_DIV_LOAD;
            vsl_pkg::ST_DIV_STEP:  ctrl.op = vsl_pkg::OP_DIV_STEP;
            vsl_pkg::ST_APPLY:     ctrl.op = vsl_pkg::OP_APPLY;
            default:               ctrl.op = vsl_pkg::OP_NONE;
        endcase
    end

endmodule

### rtl/core/vsl_unit.sv
// Shared add/subtract unit with its working registers: multiply, square root, divide.
module vsl_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vsl_pkg::ctrl_t              ctrl,
    input  logic [vsl_pkg::DataW-1:0]   tgt_x,
    input  logic [vsl_pkg::DataW-1:0]   tgt_y,
    input  logic [vsl_pkg::DataW-1:0]   tgt_z,
    input  logic [vsl_pkg::DataW-1:0]   last_x,
    input  logic [vsl_pkg::DataW-1:0]   last_y,
    input  logic [vsl_pkg::DataW-1:0]   last_z,
    input  logic [vsl_pkg::CapW-1:0]    max_step,
    output logic                        check_limited,
    output logic                        limited,
    output logic [vsl_pkg::DataW-1:0]   res_x,
    output logic [vsl_pkg::DataW-1:0]   res_y,
    output logic [vsl_pkg::DataW-1:0]   res_z
);

    logic [vsl_pkg::DiffW-1:0] d_reg   [vsl_pkg::NumComp];
    logic [vsl_pkg::MagW-1:0]  mag_reg [vsl_pkg::NumComp];
    logic [vsl_pkg::DataW-1:0] res_reg [vsl_pkg::NumComp];
    logic [vsl_pkg::AccW-1:0]  acc_reg;
    logic [vsl_pkg::AccW-1:0]  mcand_reg;
    logic [vsl_pkg::MagW-1:0]  mplier_reg;
    logic [vsl_pkg::RemW-1:0]  rem_reg;
    logic [vsl_pkg::RootW-1:0] root_reg;
    logic [vsl_pkg::CapW-1:0]  quo_reg;
    logic                      limited_reg;

    logic [vsl_pkg::DataW-1:0] tgt_sel, last_sel;
    logic [vsl_pkg::DiffW-1:0] d_sel;
    logic [vsl_pkg::MagW-1:0]  mag_sel;
    logic [vsl_pkg::AluW-1:0]  alu_a, alu_b, alu_y;
    logic                      alu_sub;
    logic                      alu_ge;
    logic [vsl_pkg::RemW+1:0]  sqrt_sh;
    logic [vsl_pkg::RootW+1:0] trial;
    logic [vsl_pkg::RemW:0]    div_sh;
    logic [vsl_pkg::DataW+1:0] sum_s;
    logic [vsl_pkg::DataW-1:0] sat_val;

    always_comb
    begin
        case (ctrl.comp)
            2'd0:
            begin
                tgt_sel  = tgt_x;
                last_sel = last_x;
                d_sel    = d_reg[0];
                mag_sel  = mag_reg[0];
            end
            2'd1:
            begin
                tgt_sel  = tgt_y;
                last_sel = last_y;
                d_sel    = d_reg[1];
                mag_sel  = mag_reg[1];
            end
            default:
            begin
                tgt_sel  = tgt_z;
                last_sel = last_z;
                d_sel    = d_reg[2];
                mag_sel  = mag_reg[2];
            end
        endcase
    end

    // Remainder shifted left with the next radicand or dividend bits brought in.
    assign sqrt_sh = {rem_reg, acc_reg[vsl_pkg::AccW-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign div_sh  = {rem_reg, acc_reg[vsl_pkg::CapW-1]};

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (ctrl.op)
            vsl_pkg::OP_DIFF:
            begin
                alu_a   = {{(vsl_pkg::AluW-vsl_pkg::DataW){tgt_sel[vsl_pkg::DataW-1]}}, tgt_sel};
                alu_b   = {{(vsl_pkg::AluW-vsl_pkg::DataW){last_sel[vsl_pkg::DataW-1]}},
                           last_sel};
                alu_sub = 1'b1;
            end
            vsl_pkg::OP_SQ_LOAD:
            begin
                alu_b   = {{(vsl_pkg::AluW-vsl_pkg::DiffW){d_sel[vsl_pkg::DiffW-1]}}, d_sel};
                alu_sub = d_sel[vsl_pkg::DiffW-1];
            end
            vsl_pkg::OP_SQ_STEP, vsl_pkg::OP_MUL_STEP:
            begin
                alu_a = vsl_pkg::AluW'(acc_reg);
                alu_b = mplier_reg[0] ? vsl_pkg::AluW'(mcand_reg) : '0;
            end
            vsl_pkg::OP_SQRT_STEP:
            begin
                alu_a   = vsl_pkg::AluW'(sqrt_sh);
                alu_b   = vsl_pkg::AluW'(trial);
                alu_sub = 1'b1;
            end
            vsl_pkg::OP_CHECK:
            begin
                alu_a   = vsl_pkg::AluW'(max_step);
                alu_b   = vsl_pkg::AluW'(root_reg);
                alu_sub = 1'b1;
            end
            vsl_pkg::OP_DIV_STEP:
            begin
                alu_a   = vsl_pkg::AluW'(div_sh);
                alu_b   = vsl_pkg::AluW'(root_reg);
                alu_sub = 1'b1;
            end
            vsl_pkg::OP_APPLY:
            begin
                alu_a   = {{(vsl_pkg::AluW-vsl_pkg::DataW){last_sel[vsl_pkg::DataW-1]}},
                           last_sel};
                alu_b   = vsl_pkg::AluW'(quo_reg);
                alu_sub = d_sel[vsl_pkg::DiffW-1];
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
        alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + vsl_pkg::AluW'(alu_sub);
    end

    assign alu_ge = ~alu_y[vsl_pkg::AluW-1];

    // The sum of squares equals root*root + rem, so it exceeds max_step squared
    // exactly when root is above max_step, or equal to it with a remainder left.
    assign check_limited = alu_y[vsl_pkg::AluW-1] | ((alu_y == '0) & (rem_reg != '0));

    always_comb
    begin
        sum_s = alu_y[vsl_pkg::DataW+1:0];
        if (sum_s[vsl_pkg::DataW+1:vsl_pkg::DataW-1] == 3'b000
            || sum_s[vsl_pkg::DataW+1:vsl_pkg::DataW-1] == 3'b111)
            sat_val = sum_s[vsl_pkg::DataW-1:0];
        else if (sum_s[vsl_pkg::DataW+1])
            sat_val = vsl_pkg::SatMin;
        else
            sat_val = vsl_pkg::SatMax;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limited_reg <= 1'b0;
        else if (ctrl.op == vsl_pkg::OP_CHECK)
            limited_reg <= check_limited;
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            vsl_pkg::OP_DIFF:
            begin
                d_reg[ctrl.comp] <= alu_y[vsl_pkg::DiffW-1:0];
                if (ctrl.comp == '0)
                    acc_reg <= '0;
            end
            vsl_pkg::OP_SQ_LOAD:
            begin
                mag_reg[ctrl.comp] <= alu_y[vsl_pkg::MagW-1:0];
                mcand_reg          <= vsl_pkg::AccW'(alu_y[vsl_pkg::MagW-1:0]);
                mplier_reg         <= alu_y[vsl_pkg::MagW-1:0];
            end
            vsl_pkg::OP_SQ_STEP, vsl_pkg::OP_MUL_STEP:
            begin
                acc_reg    <= alu_y[vsl_pkg::AccW-1:0];
                mcand_reg  <= {mcand_reg[vsl_pkg::AccW-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[vsl_pkg::MagW-1:1]};
            end
            vsl_pkg::OP_SQRT_LOAD:
            begin
                rem_reg  <= '0;
                root_reg <= '0;
            end
            vsl_pkg::OP_SQRT_STEP:
            begin
                acc_reg <= {acc_reg[vsl_pkg::AccW-3:0], 2'b00};
                if (alu_ge)
                begin
                    rem_reg  <= alu_y[vsl_pkg::RemW-1:0];
                    root_reg <= {root_reg[vsl_pkg::RootW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= sqrt_sh[vsl_pkg::RemW-1:0];
                    root_reg <= {root_reg[vsl_pkg::RootW-2:0], 1'b0};
                end
            end
            vsl_pkg::OP_MUL_LOAD:
            begin
                acc_reg    <= '0;
                mcand_reg  <= vsl_pkg::AccW'(mag_sel);
                mplier_reg <= vsl_pkg::MagW'(max_step);
            end
            vsl_pkg::OP_DIV_LOAD:
            begin
                // The quotient is at most max_step, so the upper product bits
                // already sit below the divisor.
                rem_reg <= vsl_pkg::RemW'(acc_reg[vsl_pkg::ProdW-1:vsl_pkg::CapW]);
                quo_reg <= '0;
            end
            vsl_pkg::OP_DIV_STEP:
            begin
                acc_reg <= {acc_reg[vsl_pkg::AccW-2:0], 1'b0};
                if (alu_ge)
                begin
                    rem_reg <= alu_y[vsl_pkg::RemW-1:0];
                    quo_reg <= {quo_reg[vsl_pkg::CapW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_sh[vsl_pkg::RemW-1:0];
                    quo_reg <= {quo_reg[vsl_pkg::CapW-2:0], 1'b0};
                end
            end
            vsl_pkg::OP_APPLY:
                res_reg[ctrl.comp] <= sat_val;
            default:
            begin
            end
        endcase
    end

    assign limited = limited_reg;
    assign res_x   = res_reg[0];
    assign res_y   = res_reg[1];
    assign res_z   = res_reg[2];

endmodule

### rtl/core/vector_slew_limiter.sv
// A restart or a first target skips the arithmetic; any other step goes through the shared
// add/subtract unit: a shift-add square per component, a square root, and, when limiting,
// a multiply and a divide per component. A new target is taken only after the result has
// been loaded into the output register.
// Reset clears the last vector and the has-output flag, sets max_step to 6554 and
// clears out_valid; there is no clearing pass.
`include "vector_slew_limiter_defines.svh"

module vector_slew_limiter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic [vsl_pkg::DataW-1:0]   target_x,
    input  logic [vsl_pkg::DataW-1:0]   target_y,
    input  logic [vsl_pkg::DataW-1:0]   target_z,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [vsl_pkg::DataW-1:0]   out_x,
    output logic [vsl_pkg::DataW-1:0]   out_y,
    output logic [vsl_pkg::DataW-1:0]   out_z,
    output logic                        was_limited,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [vsl_pkg::CapW-1:0]    cfg_data
);

    logic                      mode_reg;
    logic [vsl_pkg::DataW-1:0] tgt_x_reg, tgt_y_reg, tgt_z_reg;
    logic [vsl_pkg::DataW-1:0] last_x_reg, last_y_reg, last_z_reg;
    logic [vsl_pkg::DataW-1:0] last_x_next, last_y_next, last_z_next;
    logic                      has_last_reg, has_last_next;
    logic                      limited_next;
    logic [vsl_pkg::CapW-1:0]  max_step_reg;
    logic                      out_valid_reg;
    logic [vsl_pkg::DataW-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic                      was_limited_reg;

    logic                      in_fire;
    logic                      out_free;
    logic                      done;
    logic                      result_load;
    logic                      check_limited;
    logic                      limited;
    logic [vsl_pkg::DataW-1:0] res_x, res_y, res_z;
    vsl_pkg::ctrl_t            ctrl;
    logic                      out_cleared;

    assign in_fire     = in_valid & in_ready;
    assign out_free    = ~out_valid_reg | out_ready;
    assign result_load = done & out_free;
    assign cfg_ready   = 1'b1;

    vsl_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .out_free      (out_free),
        .restart       (mode_reg),
        .has_last      (has_last_reg),
        .check_limited (check_limited),
        .ctrl          (ctrl),
        .in_ready      (in_ready),
        .done          (done)
    );

    vsl_unit u_unit (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .tgt_x         (tgt_x_reg),
        .tgt_y         (tgt_y_reg),
        .tgt_z         (tgt_z_reg),
        .last_x        (last_x_reg),
        .last_y        (last_y_reg),
        .last_z        (last_z_reg),
        .max_step      (max_step_reg),
        .check_limited (check_limited),
        .limited       (limited),
        .res_x         (res_x),
        .res_y         (res_y),
        .res_z         (res_z)
    );

    // A step inside the limit lands exactly on the target, so the target is taken as is.
    always_comb
    begin
        if (mode_reg)
        begin
            last_x_next   = '0;
            last_y_next   = '0;
            last_z_next   = '0;
            has_last_next = 1'b0;
            limited_next  = 1'b0;
        end
        else if (has_last_reg && limited)
        begin
            last_x_next   = res_x;
            last_y_next   = res_y;
            last_z_next   = res_z;
            has_last_next = 1'b1;
            limited_next  = 1'b1;
        end
        else
        begin
            last_x_next   = tgt_x_reg;
            last_y_next   = tgt_y_reg;
            last_z_next   = tgt_z_reg;
            has_last_next = 1'b1;
            limited_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            last_z_reg    <= '0;
            has_last_reg  <= 1'b0;
            max_step_reg  <= vsl_pkg::MaxStepReset;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_step_reg <= cfg_data;
            if (result_load)
            begin
                last_x_reg    <= last_x_next;
                last_y_reg    <= last_y_next;
                last_z_reg    <= last_z_next;
                has_last_reg  <= has_last_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg  <= mode;
            tgt_x_reg <= target_x;
            tgt_y_reg <= target_y;
            tgt_z_reg <= target_z;
        end
        if (result_load)
        begin
            out_x_reg       <= last_x_next;
            out_y_reg       <= last_y_next;
            out_z_reg       <= last_z_next;
            was_limited_reg <= limited_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_z       = out_z_reg;
    assign was_limited = was_limited_reg;

    assign out_cleared = (out_x_reg == '0) && (out_y_reg == '0) && (out_z_reg == '0)
                         && !was_limited_reg;

    `VSL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `VSL_ASSERT_NEXT(a_result_waits, done && !out_free, done)
    `VSL_ASSERT_IMPL(a_restart_zero, out_valid_reg && !has_last_reg, out_cleared)
    `VSL_ASSERT_IMPL(a_limited_has_last, out_valid_reg && was_limited_reg, has_last_reg)

endmodule

### dv/vsl_checker.sv
// Checker: predicts each smoothed vector from the accepted targets and compares it with the block.
`timescale 1ns / 1ps

module vsl_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        mode,
    input  logic [vsl_pkg::DataW-1:0]   target_x,
    input  logic [vsl_pkg::DataW-1:0]   target_y,
    input  logic [vsl_pkg::DataW-1:0]   target_z,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [vsl_pkg::DataW-1:0]   out_x,
    input  logic [vsl_pkg::DataW-1:0]   out_y,
    input  logic [vsl_pkg::DataW-1:0]   out_z,
    input  logic                        was_limited,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [vsl_pkg::CapW-1:0]    cfg_data,
    output int                          fail_count,
    output int                          pending
);

    typedef struct packed {
        logic [vsl_pkg::DataW-1:0] x;
        logic [vsl_pkg::DataW-1:0] y;
        logic [vsl_pkg::DataW-1:0] z;
        logic                      limited;
    } slew_result_t;

    logic signed [vsl_pkg::DataW-1:0] held_x;
    logic signed [vsl_pkg::DataW-1:0] held_y;
    logic signed [vsl_pkg::DataW-1:0] held_z;
    bit                               held_valid;
    logic [vsl_pkg::CapW-1:0]         step_cap;
    slew_result_t                     smoothed_q[$];
    int                               errors = 0;

    function automatic logic [34:0] floor_sqrt(input logic [65:0] v);
        logic [34:0] r;
        logic [34:0] c;
        logic [69:0] sq;
        r = '0;
        for (int b = 34; b >= 0; b--) begin
            c  = r | (35'd1 << b);
            sq = 70'(c) * 70'(c);
            if (sq <= 70'(v))
                r = c;
        end
        return r;
    endfunction

    // Scales one difference component by cap / len, truncating toward zero.
    function automatic logic signed [32:0] scale_step(input logic signed [32:0] d,
                                                      input logic [vsl_pkg::CapW-1:0] cap,
                                                      input logic [34:0] len);
        logic [32:0] m;
        logic [63:0] q;
        m = d[32] ? 33'(-d) : 33'(d);
        q = (64'(m) * 64'(cap)) / 64'(len);
        return d[32] ? -$signed({1'b0, q[31:0]}) : $signed({1'b0, q[31:0]});
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            return vsl_pkg::SatMax;
        if (v < -34'sd2147483648)
            return vsl_pkg::SatMin;
        return v[31:0];
    endfunction

    function automatic logic [32:0] magnitude(input logic signed [32:0] d);
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

    task automatic predict_slew(input logic restart, input logic [31:0] tx,
                                input logic [31:0] ty, input logic [31:0] tz);
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic [65:0]        dist_sq;
        logic [34:0]        len;
        slew_result_t       res;
        res.limited = 1'b0;
        if (restart) begin
            held_x     = '0;
            held_y     = '0;
            held_z     = '0;
            held_valid = 1'b0;
        end else if (!held_valid) begin
            held_x     = tx;
            held_y     = ty;
            held_z     = tz;
            held_valid = 1'b1;
        end else begin
            dx = 33'($signed(tx)) - 33'(held_x);
            dy = 33'($signed(ty)) - 33'(held_y);
            dz = 33'($signed(tz)) - 33'(held_z);
            dist_sq = 66'(magnitude(dx)) * 66'(magnitude(dx))
                    + 66'(magnitude(dy)) * 66'(magnitude(dy))
                    + 66'(magnitude(dz)) * 66'(magnitude(dz));
            if (dist_sq > 66'(step_cap) * 66'(step_cap)) begin
                len = floor_sqrt(dist_sq);
                dx  = scale_step(dx, step_cap, len);
                dy  = scale_step(dy, step_cap, len);
                dz  = scale_step(dz, step_cap, len);
                res.limited = 1'b1;
            end
            held_x = clamp32(34'(dx) + 34'(held_x));
            held_y = clamp32(34'(dy) + 34'(held_y));
            held_z = clamp32(34'(dz) + 34'(held_z));
        end
        res.x = held_x;
        res.y = held_y;
        res.z = held_z;
        smoothed_q.push_back(res);
    endtask

    task automatic check_result();
        slew_result_t exp_res;
        if (smoothed_q.size() == 0) begin
            $error("result with no transaction waiting: out_x %h out_y %h out_z %h",
                   out_x, out_y, out_z);
            errors++;
        end else begin
            exp_res = smoothed_q.pop_front();
            if (out_x !== exp_res.x) begin
                $error("out_x mismatch: expected %h, actual %h", exp_res.x, out_x);
                errors++;
            end
            if (out_y !== exp_res.y) begin
                $error("out_y mismatch: expected %h, actual %h", exp_res.y, out_y);
                errors++;
            end
            if (out_z !== exp_res.z) begin
                $error("out_z mismatch: expected %h, actual %h", exp_res.z, out_z);
                errors++;
            end
            if (was_limited !== exp_res.limited) begin
                $error("was_limited mismatch: expected %b, actual %b",
                       exp_res.limited, was_limited);
                errors++;
            end
        end
    endtask

    // The result side is checked before a new input is queued, so a stray result
    // can never be matched against a transaction accepted at the same edge.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            held_x     = '0;
            held_y     = '0;
            held_z     = '0;
            held_valid = 1'b0;
            step_cap   = vsl_pkg::MaxStepReset;
            smoothed_q.delete();
        end else begin
            if (out_valid && out_ready)
                check_result();
            if (cfg_valid && cfg_ready)
                step_cap = cfg_data;
            if (in_valid && in_ready)
                predict_slew(mode, target_x, target_y, target_z);
        end
        pending    <= smoothed_q.size();
        fail_count <= errors;
    end

endmodule

### dv/tb_top.sv
// Testbench top: drives targets, step limits and output back-pressure, and reports the verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int LatencyMax = 340;
    localparam int HoldCycles = 1500;
    localparam int Phases     = 12;
    localparam int PhaseItems = 100;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       mode = 1'b0;
    logic [vsl_pkg::DataW-1:0]  target_x = '0;
    logic [vsl_pkg::DataW-1:0]  target_y = '0;
    logic [vsl_pkg::DataW-1:0]  target_z = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [vsl_pkg::DataW-1:0]  out_x;
    logic [vsl_pkg::DataW-1:0]  out_y;
    logic [vsl_pkg::DataW-1:0]  out_z;
    logic                       was_limited;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [vsl_pkg::CapW-1:0]   cfg_data = '0;
    int                         fail_count;
    int                         pending;

    bit                         steady = 1'b0;
    bit                         hold_off = 1'b0;
    logic [vsl_pkg::CapW-1:0]   cur_cap = vsl_pkg::MaxStepReset;
    logic [vsl_pkg::DataW-1:0]  anchor_x = '0;
    logic [vsl_pkg::DataW-1:0]  anchor_y = '0;
    logic [vsl_pkg::DataW-1:0]  anchor_z = '0;

    vector_slew_limiter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .target_x    (target_x),
        .target_y    (target_y),
        .target_z    (target_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .was_limited (was_limited),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    vsl_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .target_x    (target_x),
        .target_y    (target_y),
        .target_z    (target_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .was_limited (was_limited),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] near_value(input logic [31:0] anchor, input longint span);
        longint v;
        v = longint'($signed(anchor)) + longint'($urandom_range(0, 32'(2 * span))) - span;
        if (v > 64'sh7FFF_FFFF)
            v = 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            v = -64'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] extreme_value();
        case ($urandom_range(0, 4))
            0:       return vsl_pkg::SatMax;
            1:       return vsl_pkg::SatMin;
            2:       return 32'd0;
            3:       return 32'hFFFF_FFFF;
            default: return 32'd1;
        endcase
    endfunction

    // Holds valid and the payload until the transaction is taken.
    task automatic send_item(input logic m, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        target_x <= x;
        target_y <= y;
        target_z <= z;
        do @(posedge clk); while (!in_ready);
        if (!m) begin
            anchor_x = x;
            anchor_y = y;
            anchor_z = z;
        end
    endtask

    // Lowers valid and waits until every predicted result has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cap(input logic [vsl_pkg::CapW-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_cap = v;
    endtask

    function automatic logic [vsl_pkg::CapW-1:0] pick_cap();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 31'($urandom_range(1, 16));
            2:       return 31'($urandom_range(1, 262144));
            3:       return 31'($urandom_range(32'h0010_0000, 32'h1000_0000));
            4:       return '1;
            default: return 31'($urandom);
        endcase
    endfunction

    // Output side: random stalls, plus one long hold-off when requested.
    initial
    begin
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        wait (rst_n);
        forever begin
            if (hold_off && !hold_done) begin
                out_ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                gap = pick_gap();
                if (gap != 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        #25_000_000;
        $display("vector_slew_limiter test failed");
        $finish;
    end

    initial
    begin
        int     r;
        longint base;
        longint span;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset value of the step limit: first target, small step, limited steps.
        send_item(1'b0, 32'd0, 32'd0, 32'd0);
        send_item(1'b0, 32'd100, -32'sd200, 32'd300);
        send_item(1'b0, 32'h0001_0000, 32'd0, 32'd0);
        send_item(1'b0, vsl_pkg::SatMax, vsl_pkg::SatMin, vsl_pkg::SatMax);
        send_item(1'b1, 32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF);
        send_item(1'b1, vsl_pkg::SatMin, vsl_pkg::SatMax, 32'd0);
        send_item(1'b0, vsl_pkg::SatMin, vsl_pkg::SatMin, vsl_pkg::SatMin);
        send_item(1'b0, vsl_pkg::SatMax, vsl_pkg::SatMax, vsl_pkg::SatMax);
        send_item(1'b0, vsl_pkg::SatMax, vsl_pkg::SatMax, vsl_pkg::SatMax);
        drain();

        // A zero limit freezes the output on any nonzero difference.
        write_cap('0);
        send_item(1'b1, 32'd0, 32'd0, 32'd0);
        send_item(1'b0, 32'd5, 32'd5, 32'd5);
        send_item(1'b0, 32'd5, 32'd5, 32'd5);
        send_item(1'b0, 32'd6, 32'd5, 32'd5);
        drain();

        // A step exactly at the limit passes; one unit beyond it gets scaled.
        write_cap(31'd5);
        send_item(1'b1, 32'd0, 32'd0, 32'd0);
        send_item(1'b0, 32'd0, 32'd0, 32'd0);
        send_item(1'b0, 32'd3, 32'd4, 32'd0);
        send_item(1'b0, 32'd6, 32'd8, 32'd1);
        send_item(1'b0, -32'sd10, -32'sd10, -32'sd10);
        drain();

        write_cap('1);
        send_item(1'b0, vsl_pkg::SatMin, vsl_pkg::SatMin, vsl_pkg::SatMin);
        send_item(1'b0, vsl_pkg::SatMax, 32'd0, vsl_pkg::SatMin);
        send_item(1'b0, vsl_pkg::SatMax, vsl_pkg::SatMax, vsl_pkg::SatMax);
        drain();

        for (int phase = 0; phase < Phases; phase++) begin
            write_cap(pick_cap());
            steady = ($urandom_range(0, 4) == 0);
            if (phase == 2)
                hold_off = 1'b1;
            base = (cur_cap < 16) ? 64'sd16 : longint'(cur_cap);
            if (base > 64'sd1073741824)
                base = 64'sd1073741824;
            for (int n = 0; n < PhaseItems; n++) begin
                span = base >> $urandom_range(0, 2);
                r = $urandom_range(0, 99);
                if (r < 5)
                    send_item(1'b1, $urandom, $urandom, $urandom);
                else if (r < 45)
                    send_item(1'b0, near_value(anchor_x, span), near_value(anchor_y, span),
                              near_value(anchor_z, span));
                else if (r < 75)
                    send_item(1'b0, $urandom, $urandom, $urandom);
                else if (r < 88)
                    send_item(1'b0, extreme_value(), extreme_value(), extreme_value());
                else
                    send_item(1'b0, anchor_x, anchor_y, anchor_z);
            end
            drain();
        end

        steady = 1'b0;
        repeat (LatencyMax) @(posedge clk);
        if (fail_count == 0)
            $display("vector_slew_limiter test passed");
        else
            $display("vector_slew_limiter test failed");
        $finish;
    end

endmodule

### vector_slew_limiter.f
+incdir+rtl/core
rtl/core/vsl_pkg.sv
rtl/core/vsl_seq.sv
rtl/core/vsl_unit.sv
rtl/core/vector_slew_limiter.sv
dv/vsl_checker.sv
dv/tb_top.sv
